### rtl/core/clp_pkg.sv
// Cursor linked list pool: shared types, request and status codes.
// Used by the top level and by the bench; depends on nothing.
`default_nettype none
package clp_pkg;

	localparam int CLP_NODE_COUNT = 256;
	localparam int CLP_LIST_COUNT = 16;

	localparam logic [3:0] OP_CREATE  = 4'd0;
	localparam logic [3:0] OP_COUNT   = 4'd1;
	localparam logic [3:0] OP_FIRST   = 4'd2;
	localparam logic [3:0] OP_NEXT    = 4'd3;
	localparam logic [3:0] OP_PREV    = 4'd4;
	localparam logic [3:0] OP_CURR    = 4'd5;
	localparam logic [3:0] OP_LAST    = 4'd6;
	localparam logic [3:0] OP_ADD     = 4'd7;
	localparam logic [3:0] OP_INSERT  = 4'd8;
	localparam logic [3:0] OP_APPEND  = 4'd9;
	localparam logic [3:0] OP_PREPEND = 4'd10;
	localparam logic [3:0] OP_REMOVE  = 4'd11;
	localparam logic [3:0] OP_TRIM    = 4'd12;
	localparam logic [3:0] OP_CONCAT  = 4'd13;
	localparam logic [3:0] OP_SEARCH  = 4'd14;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_NF     = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;
	localparam logic [1:0] ST_NOHEAD = 2'd3;

	localparam logic [2:0] F_USE    = 3'b001;
	localparam logic [2:0] F_BEFORE = 3'b010;
	localparam logic [2:0] F_BEYOND = 3'b100;

	typedef struct packed {
		logic [3:0]  req_type;
		logic [3:0]  list_id;
		logic [3:0]  other_list;
		logic [31:0] item_value;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] item_out;
		logic [3:0]  list_out;
		logic [8:0]  count_out;
	} rsp_t;

endpackage
`default_nettype wire

### rtl/core/clp_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
// Standalone; used for the node pool arrays.
`default_nettype none
module clp_ram #(
	parameter int DEPTH = 2,
	parameter int WIDTH = 1
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] waddr,
	input  wire [WIDTH-1:0]         wdata,
	input  wire                     re,
	input  wire [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]        rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

### rtl/core/cursor_linked_list_pool_top.sv
// Cursor linked list pool top level: request sequencer, list heads, node RAMs.
// Depends on clp_pkg and clp_ram.
//
// Usage:
//  A request (req) transfers at a rising edge with start high and busy low.
//  busy stays high while the request is worked on; exactly one result (rsp)
//  follows per request, shown for one cycle with done high. The receiver
//  cannot stall, so a result is simply taken in the cycle done is high.
//  After the transfer, create, count and requests that fail early end in
//  dispatch; first, last, curr read the item; next, prev read the link,
//  then its item if any, or only the item when the cursor is off the list;
//  concat joins the lists, then frees the other head; add, insert, append
//  and prepend pass ADD1, ADD2, ADD3; remove, trim REM1, REM2; search one
//  node per step. Each node RAM does a registered read and a write per cycle.
//  A new request can transfer in the cycle done is high.
//  Reset (arst_n low) empties every list, frees all heads and rebuilds the
//  node free chain in order; no clearing pass is needed, a fill pointer
//  tracks nodes never handed out.
`default_nettype none
module cursor_linked_list_pool_top #(
	parameter int NODE_COUNT = clp_pkg::CLP_NODE_COUNT,
	parameter int LIST_COUNT = clp_pkg::CLP_LIST_COUNT
) (
	input  wire           clk,
	input  wire           arst_n,
	input  wire           start,
	input  clp_pkg::req_t req,
	output logic          busy,
	output logic          done,
	output clp_pkg::rsp_t rsp
);
	import clp_pkg::*;

	localparam int NW = $clog2(NODE_COUNT + 1);
	localparam int IW = $clog2(NODE_COUNT);
	localparam int LW = (LIST_COUNT > 1) ? $clog2(LIST_COUNT) : 1;
	localparam logic [NW-1:0] NIL = NW'(NODE_COUNT);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_DISP = 4'd1;
	localparam logic [3:0] S_ITEM = 4'd2;
	localparam logic [3:0] S_NAV  = 4'd3;
	localparam logic [3:0] S_ADD1 = 4'd4;
	localparam logic [3:0] S_ADD2 = 4'd5;
	localparam logic [3:0] S_ADD3 = 4'd6;
	localparam logic [3:0] S_REM1 = 4'd7;
	localparam logic [3:0] S_REM2 = 4'd8;
	localparam logic [3:0] S_CAT2 = 4'd9;
	localparam logic [3:0] S_SRCH = 4'd10;

	typedef struct packed {
		logic [NW-1:0] first;
		logic [NW-1:0] last;
		logic [NW-1:0] cursor;
		logic [NW-1:0] size;
		logic [2:0]    flags;
	} head_t;

	localparam head_t HEAD_RST = '{first: NIL, last: NIL, cursor: NIL, size: '0,
		flags: F_BEFORE | F_BEYOND};

	function automatic head_t set_cur(head_t hd, logic [NW-1:0] n, logic [2:0] off);
		head_t r;
		r = hd;
		r.cursor = n;
		r.flags = (n == NIL) ? (F_USE | off) : F_USE;
		if (r.size == '0) begin
			r.flags = F_USE | F_BEFORE | F_BEYOND;
		end
		return r;
	endfunction

	logic [3:0]    state_q, state_d;
	logic [3:0]    op_q, h_q, o_q;
	logic [31:0]   val_q;
	logic          valid_q;
	head_t         hr_q, hr_d;
	logic [NW-1:0] n_q, n_d, p_q, p_d, x_q, x_d;
	logic [NW-1:0] free_head_q, fh_d, fresh_q, fr_d;
	head_t         heads_q [LIST_COUNT];
	head_t         head_rd;
	logic [LW-1:0] hsel, hidx;

	logic          hw_en;
	logic [LW-1:0] hw_idx;
	head_t         hw_rec;

	logic          it_we, it_re, nx_we, nx_re, pv_we, pv_re;
	logic [IW-1:0] it_wa, it_ra, nx_wa, nx_ra, pv_wa, pv_ra;
	logic [31:0]   it_wd, it_rd;
	logic [NW-1:0] nx_wd, nx_rd, pv_wd, pv_rd;

	logic          fin;
	rsp_t          fin_rsp, res_q;
	logic          done_q;

	logic          cre_found;
	logic [LW-1:0] cre_idx;
	logic          o_ok;
	logic [NW-1:0] cand, tp, tx;
	logic [2:0]    off;

	assign hidx = LW'(h_q);
	assign hsel = (state_q == S_IDLE) ? LW'(req.list_id) : LW'(o_q);
	assign head_rd = heads_q[hsel];
	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp = res_q;

	clp_ram #(.DEPTH(NODE_COUNT), .WIDTH(32)) u_item (
		.clk(clk), .we(it_we), .waddr(it_wa), .wdata(it_wd),
		.re(it_re), .raddr(it_ra), .rdata(it_rd)
	);
	clp_ram #(.DEPTH(NODE_COUNT), .WIDTH(NW)) u_next (
		.clk(clk), .we(nx_we), .waddr(nx_wa), .wdata(nx_wd),
		.re(nx_re), .raddr(nx_ra), .rdata(nx_rd)
	);
	clp_ram #(.DEPTH(NODE_COUNT), .WIDTH(NW)) u_prev (
		.clk(clk), .we(pv_we), .waddr(pv_wa), .wdata(pv_wd),
		.re(pv_re), .raddr(pv_ra), .rdata(pv_rd)
	);

	always_comb begin
		cre_found = 1'b0;
		cre_idx = '0;
		for (int i = LIST_COUNT - 1; i >= 0; i--) begin
			if (!(heads_q[i].flags[0])) begin
				cre_found = 1'b1;
				cre_idx = LW'(i);
			end
		end
	end

	always_comb begin
		state_d = state_q;
		hr_d = hr_q;
		n_d = n_q;
		p_d = p_q;
		x_d = x_q;
		fh_d = free_head_q;
		fr_d = fresh_q;
		hw_en = 1'b0;
		hw_idx = hidx;
		hw_rec = hr_q;
		it_we = 1'b0; it_wa = '0; it_wd = val_q; it_re = 1'b0; it_ra = '0;
		nx_we = 1'b0; nx_wa = '0; nx_wd = '0; nx_re = 1'b0; nx_ra = '0;
		pv_we = 1'b0; pv_wa = '0; pv_wd = '0; pv_re = 1'b0; pv_ra = '0;
		fin = 1'b0;
		fin_rsp = '{status: ST_NF, item_out: '0, list_out: '0, count_out: '0};
		o_ok = 1'b0;
		cand = NIL;
		tp = NIL;
		tx = NIL;
		off = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				if (op_q == OP_CREATE) begin
					fin = 1'b1;
					state_d = S_IDLE;
					if (cre_found) begin
						hw_en = 1'b1;
						hw_idx = cre_idx;
						hw_rec = HEAD_RST;
						hw_rec.flags = F_USE | F_BEFORE | F_BEYOND;
						fin_rsp.status = ST_OK;
						fin_rsp.list_out = 4'(cre_idx);
					end else begin
						fin_rsp.status = ST_NOHEAD;
					end
				end else if (!valid_q) begin
					fin = 1'b1;
					state_d = S_IDLE;
				end else begin
					fin_rsp.count_out = 9'(hr_q.size);
					case (op_q)
						OP_COUNT: begin
							fin = 1'b1;
							fin_rsp.status = ST_OK;
							state_d = S_IDLE;
						end
						OP_FIRST, OP_LAST, OP_NEXT, OP_PREV, OP_CURR: begin
							if (hr_q.cursor != NIL && op_q == OP_NEXT) begin
								nx_re = 1'b1;
								nx_ra = IW'(hr_q.cursor);
								state_d = S_NAV;
							end else if (hr_q.cursor != NIL && op_q == OP_PREV) begin
								pv_re = 1'b1;
								pv_ra = IW'(hr_q.cursor);
								state_d = S_NAV;
							end else if (op_q == OP_CURR) begin
								if (hr_q.cursor != NIL) begin
									it_re = 1'b1;
									it_ra = IW'(hr_q.cursor);
									state_d = S_ITEM;
								end else begin
									fin = 1'b1;
									state_d = S_IDLE;
								end
							end else if (hr_q.size != '0 && (op_q == OP_FIRST
									|| (op_q == OP_NEXT && hr_q.flags[1]))) begin
								hr_d = set_cur(hr_q, hr_q.first, '0);
								hw_en = 1'b1;
								hw_rec = hr_d;
								it_re = 1'b1;
								it_ra = IW'(hr_q.first);
								state_d = S_ITEM;
							end else if (hr_q.size != '0 && (op_q == OP_LAST
									|| (op_q == OP_PREV && hr_q.flags[2]))) begin
								hr_d = set_cur(hr_q, hr_q.last, '0);
								hw_en = 1'b1;
								hw_rec = hr_d;
								it_re = 1'b1;
								it_ra = IW'(hr_q.last);
								state_d = S_ITEM;
							end else begin
								fin = 1'b1;
								state_d = S_IDLE;
							end
						end
						OP_ADD, OP_INSERT, OP_APPEND, OP_PREPEND: begin
							if (free_head_q == NIL) begin
								fin = 1'b1;
								fin_rsp.status = ST_FULL;
								state_d = S_IDLE;
							end else begin
								n_d = free_head_q;
								nx_re = 1'b1;
								nx_ra = IW'(free_head_q);
								pv_re = 1'b1;
								pv_ra = IW'(hr_q.cursor);
								it_we = 1'b1;
								it_wa = IW'(free_head_q);
								if (op_q == OP_APPEND) begin
									hr_d.cursor = NIL;
									hr_d.flags = F_USE | F_BEYOND;
								end else if (op_q == OP_PREPEND) begin
									hr_d.cursor = NIL;
									hr_d.flags = F_USE | F_BEFORE;
								end
								state_d = S_ADD1;
							end
						end
						OP_REMOVE, OP_TRIM: begin
							if (op_q == OP_REMOVE && hr_q.cursor != NIL) begin
								cand = hr_q.cursor;
							end else if (op_q == OP_TRIM && hr_q.size != '0) begin
								cand = hr_q.last;
							end
							if (cand != NIL) begin
								n_d = cand;
								nx_re = 1'b1; nx_ra = IW'(cand);
								pv_re = 1'b1; pv_ra = IW'(cand);
								it_re = 1'b1; it_ra = IW'(cand);
								state_d = S_REM1;
							end else begin
								fin = 1'b1;
								state_d = S_IDLE;
							end
						end
						OP_CONCAT: begin
							o_ok = (32'(o_q) < LIST_COUNT) && (o_q != h_q)
								&& head_rd.flags[0];
							if (o_ok) begin
								if (head_rd.size != '0) begin
									if (hr_q.size == '0) begin
										hr_d.first = head_rd.first;
									end else begin
										nx_we = 1'b1;
										nx_wa = IW'(hr_q.last);
										nx_wd = head_rd.first;
										pv_we = 1'b1;
										pv_wa = IW'(head_rd.first);
										pv_wd = hr_q.last;
									end
									hr_d.last = head_rd.last;
									hr_d.size = hr_q.size + head_rd.size;
									if (hr_q.cursor == NIL) begin
										hr_d.flags = hr_q.flags & (hr_q.flags[1] ?
											(F_USE | F_BEFORE) : (F_USE | F_BEYOND));
									end
								end
								hw_en = 1'b1;
								hw_rec = hr_d;
								state_d = S_CAT2;
							end else begin
								fin = 1'b1;
								state_d = S_IDLE;
							end
						end
						OP_SEARCH: begin
							cand = hr_q.cursor;
							if (cand == NIL && hr_q.flags[1]) begin
								cand = hr_q.first;
							end
							if (cand == NIL) begin
								hr_d = set_cur(hr_q, NIL, F_BEYOND);
								hw_en = 1'b1;
								hw_rec = hr_d;
								fin = 1'b1;
								state_d = S_IDLE;
							end else begin
								n_d = cand;
								it_re = 1'b1; it_ra = IW'(cand);
								nx_re = 1'b1; nx_ra = IW'(cand);
								state_d = S_SRCH;
							end
						end
						default: begin
							fin = 1'b1;
							fin_rsp.count_out = '0;
							state_d = S_IDLE;
						end
					endcase
				end
			end
			S_NAV: begin
				cand = (op_q == OP_NEXT) ? nx_rd : pv_rd;
				off = (op_q == OP_NEXT) ? F_BEYOND : F_BEFORE;
				hr_d = set_cur(hr_q, cand, off);
				hw_en = 1'b1;
				hw_rec = hr_d;
				if (cand != NIL) begin
					it_re = 1'b1;
					it_ra = IW'(cand);
					state_d = S_ITEM;
				end else begin
					fin = 1'b1;
					fin_rsp.count_out = 9'(hr_q.size);
					state_d = S_IDLE;
				end
			end
			S_ITEM: begin
				fin = 1'b1;
				fin_rsp.status = ST_OK;
				fin_rsp.item_out = it_rd;
				fin_rsp.count_out = 9'(hr_q.size);
				state_d = S_IDLE;
			end
			S_ADD1: begin
				if (n_q == fresh_q) begin
					fh_d = n_q + NW'(1);
					fr_d = fresh_q + NW'(1);
				end else begin
					fh_d = nx_rd;
				end
				nx_re = 1'b1;
				nx_ra = IW'(hr_q.cursor);
				state_d = S_ADD2;
			end
			S_ADD2: begin
				if (hr_q.size == '0) begin
					tp = NIL; tx = NIL;
				end else if (hr_q.cursor == NIL) begin
					if (hr_q.flags[1]) begin
						tp = NIL; tx = hr_q.first;
					end else begin
						tp = hr_q.last; tx = NIL;
					end
				end else if (op_q == OP_INSERT) begin
					tp = pv_rd; tx = hr_q.cursor;
				end else begin
					tp = hr_q.cursor; tx = nx_rd;
				end
				p_d = tp;
				x_d = tx;
				pv_we = 1'b1; pv_wa = IW'(n_q); pv_wd = tp;
				nx_we = 1'b1; nx_wa = IW'(n_q); nx_wd = tx;
				state_d = S_ADD3;
			end
			S_ADD3: begin
				if (p_q != NIL) begin
					nx_we = 1'b1; nx_wa = IW'(p_q); nx_wd = n_q;
				end else begin
					hr_d.first = n_q;
				end
				if (x_q != NIL) begin
					pv_we = 1'b1; pv_wa = IW'(x_q); pv_wd = n_q;
				end else begin
					hr_d.last = n_q;
				end
				hr_d.cursor = n_q;
				hr_d.flags = F_USE;
				hr_d.size = hr_q.size + NW'(1);
				hw_en = 1'b1;
				hw_rec = hr_d;
				fin = 1'b1;
				fin_rsp.status = ST_OK;
				fin_rsp.count_out = 9'(hr_d.size);
				state_d = S_IDLE;
			end
			S_REM1: begin
				p_d = pv_rd;
				x_d = nx_rd;
				if (pv_rd != NIL) begin
					nx_we = 1'b1; nx_wa = IW'(pv_rd); nx_wd = nx_rd;
				end
				if (nx_rd != NIL) begin
					pv_we = 1'b1; pv_wa = IW'(nx_rd); pv_wd = pv_rd;
				end
				state_d = S_REM2;
			end
			S_REM2: begin
				nx_we = 1'b1; nx_wa = IW'(n_q); nx_wd = free_head_q;
				fh_d = n_q;
				if (p_q == NIL) begin
					hr_d.first = x_q;
				end
				if (x_q == NIL) begin
					hr_d.last = p_q;
				end
				hr_d.size = hr_q.size - NW'(1);
				hr_d = set_cur(hr_d, (op_q == OP_TRIM) ? hr_d.last : x_q, F_BEYOND);
				hw_en = 1'b1;
				hw_rec = hr_d;
				fin = 1'b1;
				fin_rsp.status = ST_OK;
				fin_rsp.item_out = it_rd;
				fin_rsp.count_out = 9'(hr_d.size);
				state_d = S_IDLE;
			end
			S_CAT2: begin
				hw_en = 1'b1;
				hw_idx = LW'(o_q);
				hw_rec = HEAD_RST;
				fin = 1'b1;
				fin_rsp.status = ST_OK;
				fin_rsp.count_out = 9'(hr_q.size);
				state_d = S_IDLE;
			end
			S_SRCH: begin
				if (it_rd == val_q) begin
					hr_d = set_cur(hr_q, n_q, F_BEYOND);
					hw_en = 1'b1;
					hw_rec = hr_d;
					fin = 1'b1;
					fin_rsp.status = ST_OK;
					fin_rsp.item_out = it_rd;
					fin_rsp.count_out = 9'(hr_q.size);
					state_d = S_IDLE;
				end else if (nx_rd == NIL) begin
					hr_d = set_cur(hr_q, NIL, F_BEYOND);
					hw_en = 1'b1;
					hw_rec = hr_d;
					fin = 1'b1;
					fin_rsp.count_out = 9'(hr_q.size);
					state_d = S_IDLE;
				end else begin
					n_d = nx_rd;
					it_re = 1'b1; it_ra = IW'(nx_rd);
					nx_re = 1'b1; nx_ra = IW'(nx_rd);
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			free_head_q <= '0;
			fresh_q <= '0;
			done_q <= 1'b0;
			for (int i = 0; i < LIST_COUNT; i++) begin
				heads_q[i] <= HEAD_RST;
			end
		end else begin
			state_q <= state_d;
			free_head_q <= fh_d;
			fresh_q <= fr_d;
			done_q <= fin;
			if (hw_en) begin
				heads_q[hw_idx] <= hw_rec;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			op_q <= req.req_type;
			h_q <= req.list_id;
			o_q <= req.other_list;
			val_q <= req.item_value;
			hr_q <= head_rd;
			valid_q <= (32'(req.list_id) < LIST_COUNT) && head_rd.flags[0];
		end else begin
			hr_q <= hr_d;
		end
		n_q <= n_d;
		p_q <= p_d;
		x_q <= x_d;
		if (fin) begin
			res_q <= fin_rsp;
		end
	end

`ifndef SYNTHESIS
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("result without a request in flight");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accepted request did not raise busy");
	a_free_fill: assert property (@(posedge clk) disable iff (!arst_n)
		free_head_q <= fresh_q || free_head_q == NIL)
		else $error("free chain head beyond fill pointer");
`endif
endmodule
`default_nettype wire

### bench/tb_top.sv
// Self-checking bench for the cursor linked list pool: directed and random list traffic,
// predicted results in a scoreboard class. Depends on clp_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top;
	import clp_pkg::*;

	class list_pool_scoreboard;
		localparam int NIL = CLP_NODE_COUNT;
		logic [31:0] item_mem[CLP_NODE_COUNT];
		int next_mem[CLP_NODE_COUNT];
		int prev_mem[CLP_NODE_COUNT];
		int free_ptr;
		int first_q[CLP_LIST_COUNT];
		int last_q[CLP_LIST_COUNT];
		int cur_q[CLP_LIST_COUNT];
		int size_q[CLP_LIST_COUNT];
		logic [2:0] flags_q[CLP_LIST_COUNT];
		rsp_t pending[$];
		int errors;

		function new();
			errors = 0;
			for (int i = 0; i < CLP_NODE_COUNT; i++) begin
				item_mem[i] = '0;
				prev_mem[i] = 0;
				next_mem[i] = i + 1;
			end
			free_ptr = 0;
			for (int i = 0; i < CLP_LIST_COUNT; i++)
				clear_head(i);
		endfunction

		function void clear_head(int h);
			first_q[h] = NIL;
			last_q[h] = NIL;
			cur_q[h] = NIL;
			size_q[h] = 0;
			flags_q[h] = F_BEFORE | F_BEYOND;
		endfunction

		function void move_cursor(int h, int n, logic [2:0] off);
			cur_q[h] = n;
			flags_q[h] = (n == NIL) ? (F_USE | off) : F_USE;
			if (size_q[h] == 0)
				flags_q[h] = F_USE | F_BEFORE | F_BEYOND;
		endfunction

		function void link_node(int h, int n, bit before_cur);
			int c, p, x;
			c = cur_q[h];
			if (size_q[h] == 0) begin
				p = NIL;
				x = NIL;
			end else if (c == NIL) begin
				if (flags_q[h] & F_BEFORE) begin
					p = NIL;
					x = first_q[h];
				end else begin
					p = last_q[h];
					x = NIL;
				end
			end else if (before_cur) begin
				p = prev_mem[c];
				x = c;
			end else begin
				p = c;
				x = next_mem[c];
			end
			prev_mem[n] = p;
			next_mem[n] = x;
			if (p == NIL) first_q[h] = n; else next_mem[p] = n;
			if (x == NIL) last_q[h] = n; else prev_mem[x] = n;
			cur_q[h] = n;
			flags_q[h] = F_USE;
			size_q[h]++;
		endfunction

		function void unlink(int h, int n);
			int p, x;
			p = prev_mem[n];
			x = next_mem[n];
			if (p == NIL) first_q[h] = x; else next_mem[p] = x;
			if (x == NIL) last_q[h] = p; else prev_mem[x] = p;
			size_q[h]--;
			next_mem[n] = free_ptr;
			free_ptr = n;
		endfunction

		function bit list_live(int h);
			return flags_q[h][0];
		endfunction

		function void note_request(req_t r);
			rsp_t e;
			int h, o, c, n, i;
			h = r.list_id;
			o = r.other_list;
			e = '0;
			e.status = ST_NF;
			if (r.req_type == OP_CREATE) begin
				e.status = ST_NOHEAD;
				for (i = 0; i < CLP_LIST_COUNT; i++)
					if (!list_live(i)) begin
						clear_head(i);
						flags_q[i] |= F_USE;
						e.status = ST_OK;
						e.list_out = 4'(i);
						break;
					end
			end else if (list_live(h) && r.req_type <= OP_SEARCH) begin
				c = cur_q[h];
				case (r.req_type)
					OP_COUNT: e.status = ST_OK;
					OP_FIRST, OP_LAST: if (size_q[h] != 0) begin
						n = (r.req_type == OP_FIRST) ? first_q[h] : last_q[h];
						move_cursor(h, n, '0);
						e.status = ST_OK;
						e.item_out = item_mem[n];
					end
					OP_NEXT: if (c == NIL) begin
						if ((flags_q[h] & F_BEFORE) && size_q[h] != 0) begin
							n = first_q[h];
							move_cursor(h, n, '0);
							e.status = ST_OK;
							e.item_out = item_mem[n];
						end
					end else begin
						n = next_mem[c];
						move_cursor(h, n, F_BEYOND);
						if (n != NIL) begin
							e.status = ST_OK;
							e.item_out = item_mem[n];
						end
					end
					OP_PREV: if (c == NIL) begin
						if ((flags_q[h] & F_BEYOND) && size_q[h] != 0) begin
							n = last_q[h];
							move_cursor(h, n, '0);
							e.status = ST_OK;
							e.item_out = item_mem[n];
						end
					end else begin
						n = prev_mem[c];
						move_cursor(h, n, F_BEFORE);
						if (n != NIL) begin
							e.status = ST_OK;
							e.item_out = item_mem[n];
						end
					end
					OP_CURR: if (c != NIL) begin
						e.status = ST_OK;
						e.item_out = item_mem[c];
					end
					OP_ADD, OP_INSERT, OP_APPEND, OP_PREPEND: if (free_ptr >= NIL) begin
						e.status = ST_FULL;
					end else begin
						n = free_ptr;
						free_ptr = next_mem[n];
						item_mem[n] = r.item_value;
						if (r.req_type == OP_APPEND) begin
							cur_q[h] = NIL;
							flags_q[h] = F_USE | F_BEYOND;
						end
						if (r.req_type == OP_PREPEND) begin
							cur_q[h] = NIL;
							flags_q[h] = F_USE | F_BEFORE;
						end
						link_node(h, n, r.req_type == OP_INSERT);
						e.status = ST_OK;
					end
					OP_REMOVE: if (c != NIL) begin
						n = next_mem[c];
						e.item_out = item_mem[c];
						unlink(h, c);
						move_cursor(h, n, F_BEYOND);
						e.status = ST_OK;
					end
					OP_TRIM: if (size_q[h] != 0) begin
						n = last_q[h];
						e.item_out = item_mem[n];
						unlink(h, n);
						move_cursor(h, last_q[h], F_BEYOND);
						e.status = ST_OK;
					end
					OP_CONCAT: if (o != h && list_live(o)) begin
						if (size_q[o] != 0) begin
							if (size_q[h] == 0) begin
								first_q[h] = first_q[o];
							end else begin
								next_mem[last_q[h]] = first_q[o];
								prev_mem[first_q[o]] = last_q[h];
							end
							last_q[h] = last_q[o];
							size_q[h] += size_q[o];
							if (cur_q[h] == NIL)
								flags_q[h] &= (flags_q[h] & F_BEFORE) ?
									(F_USE | F_BEFORE) : (F_USE | F_BEYOND);
						end
						clear_head(o);
						e.status = ST_OK;
					end
					default: begin
						n = c;
						if (n == NIL && (flags_q[h] & F_BEFORE)) n = first_q[h];
						for (i = 0; i < CLP_NODE_COUNT && n != NIL; i++) begin
							if (item_mem[n] == r.item_value) break;
							n = next_mem[n];
						end
						if (i >= CLP_NODE_COUNT) n = NIL;
						move_cursor(h, n, F_BEYOND);
						if (n != NIL) begin
							e.status = ST_OK;
							e.item_out = item_mem[n];
						end
					end
				endcase
				e.count_out = 9'(size_q[h]);
			end
			pending.push_back(e);
		endfunction

		function void report(string what);
			$display("mismatch: %s", what);
			errors++;
		endfunction

		function void check_result(rsp_t got);
			rsp_t e;
			if (pending.size() == 0) begin
				report("result with none pending");
				return;
			end
			e = pending.pop_front();
			if (got.status !== e.status)
				report($sformatf("status %0d exp %0d", got.status, e.status));
			if (got.item_out !== e.item_out)
				report($sformatf("item %h exp %h", got.item_out, e.item_out));
			if (got.list_out !== e.list_out)
				report($sformatf("list %0d exp %0d", got.list_out, e.list_out));
			if (got.count_out !== e.count_out)
				report($sformatf("count %0d exp %0d", got.count_out, e.count_out));
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	req_t req = '0;
	logic busy, done;
	rsp_t rsp;
	list_pool_scoreboard sb;
	int idle_pct = 0;
	int quiet_cycles = 0;
	logic [31:0] recent_vals[$];

	cursor_linked_list_pool_top u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .req(req),
		.busy(busy), .done(done), .rsp(rsp)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (done) sb.check_result(rsp);
			if ((start && !busy) || done) quiet_cycles <= 0;
			else quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles > 2000) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// start stays high between back-to-back transfers; it drops only while idling
	task automatic send(logic [3:0] op, logic [3:0] h, logic [3:0] o, logic [31:0] v);
		while ($urandom_range(99) < idle_pct) begin
			start <= 0;
			@(negedge clk);
		end
		req <= '{req_type: op, list_id: h, other_list: o, item_value: v};
		start <= 1;
		do @(posedge clk); while (busy);
		sb.note_request(req);
		@(negedge clk);
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(3))
			0: return recent_vals.size() ? recent_vals[$urandom_range(recent_vals.size() - 1)]
				: 32'hFFFF_FFFF;
			1: return $urandom_range(7);
			default: return $urandom;
		endcase
	endfunction

	task automatic random_ops(int num);
		logic [3:0] op, h, o;
		logic [31:0] v;
		repeat (num) begin
			if ($urandom_range(9) == 0) op = 4'($urandom_range(15));
			else if ($urandom_range(1)) op = 4'($urandom_range(OP_ADD, OP_PREPEND));
			else op = 4'($urandom_range(OP_COUNT, OP_SEARCH));
			if ($urandom_range(19) == 0) op = OP_CREATE;
			if (op == OP_CONCAT && $urandom_range(3) != 0) op = OP_TRIM;
			h = ($urandom_range(19) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(5));
			o = ($urandom_range(7) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(5));
			v = pick_value();
			if (recent_vals.size() > 16) void'(recent_vals.pop_front());
			recent_vals.push_back(v);
			send(op, h, o, v);
		end
	endtask

	initial begin
		sb = new();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;
		// directed
		send(OP_COUNT, 4'd0, 4'd0, 0);
		send(OP_FIRST, 4'd15, 4'd0, 0);
		send(4'd15, 4'd0, 4'd0, 0);
		send(OP_CREATE, 4'd0, 4'd0, 0);
		send(OP_FIRST, 4'd0, 4'd0, 0);
		send(OP_REMOVE, 4'd0, 4'd0, 0);
		send(OP_TRIM, 4'd0, 4'd0, 0);
		send(OP_ADD, 4'd0, 4'd0, 32'hFFFF_FFFF);
		send(OP_INSERT, 4'd0, 4'd0, 32'h0);
		send(OP_APPEND, 4'd0, 4'd0, 32'hA5A5_5A5A);
		send(OP_PREPEND, 4'd0, 4'd0, 32'h5A5A_A5A5);
		send(OP_NEXT, 4'd0, 4'd0, 0);
		send(OP_PREV, 4'd0, 4'd0, 0);
		send(OP_PREV, 4'd0, 4'd0, 0);
		send(OP_NEXT, 4'd0, 4'd0, 0);
		send(OP_CURR, 4'd0, 4'd0, 0);
		send(OP_LAST, 4'd0, 4'd0, 0);
		send(OP_NEXT, 4'd0, 4'd0, 0);
		send(OP_NEXT, 4'd0, 4'd0, 0);
		send(OP_SEARCH, 4'd0, 4'd0, 32'h0);
		send(OP_CREATE, 4'd0, 4'd0, 0);
		send(OP_APPEND, 4'd1, 4'd0, 32'h1234_5678);
		send(OP_CONCAT, 4'd0, 4'd0, 0);
		send(OP_CONCAT, 4'd0, 4'd1, 0);
		send(OP_SEARCH, 4'd0, 4'd0, 32'hDEAD_BEEF);
		repeat (14) send(OP_CREATE, 4'd0, 4'd0, 0);
		send(OP_CREATE, 4'd0, 4'd0, 0);
		// pool exhaustion, then partial drain
		repeat (257) send(OP_APPEND, 4'd2, 4'd0, $urandom);
		send(OP_SEARCH, 4'd2, 4'd0, 32'h0);
		repeat (100) send(OP_TRIM, 4'd2, 4'd0, 0);
		idle_pct = 0;   random_ops(38);
		idle_pct = 66;  random_ops(38);
		idle_pct = 13;  random_ops(38);
		idle_pct = 0;   random_ops(38);
		start <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule

### sim.f
rtl/core/clp_pkg.sv
rtl/core/clp_ram.sv
rtl/core/cursor_linked_list_pool_top.sv
bench/tb_top.sv
